// ===== rtl/core/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

  // Longest key that is kept; later key bytes are dropped.
  localparam int unsigned MAX_KEY_BYTES = 256;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_in;
    logic       last;
  } rc4_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } rc4_out_t;

  // Write port of the permutation memory.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } perm_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_J,
    ST_RD_T,
    ST_XOR,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WJ,
    ST_KS_WN
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/rc4_perm_mem.sv =====
`default_nettype none

// 256 x 8 permutation memory, one read and one write a cycle, registered read.
// Per-entry valid flops; an entry never written since the last clear reads
// as its own index (identity).
module rc4_perm_mem
  import rc4_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       clr_i,
  input  wire logic [7:0] rd_addr_i,
  input  wire perm_wr_t   wr_i,
  output logic      [7:0] rd_data_o
);

  logic [7:0]   mem [256];
  logic [255:0] vld_q;
  logic [7:0]   rd_q;
  logic [7:0]   rd_addr_q;
  logic         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q      <= mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : rd_addr_q;

endmodule

`default_nettype wire

// ===== rtl/core/rc4_stream_cipher_unit.sv =====
`default_nettype none

// RC4 engine. Key bytes (op = 0) are collected one per request, up to 256;
// the key byte flagged last starts the key schedule, which resets the
// permutation to identity and runs 256 swap steps over the key repeated.
// Data bytes (op = 1) each step the keystream generator once and return
// byte_in XOR keystream with last copied to out_last; key requests return
// nothing. A data byte needs three dependent reads of the single-read-port
// permutation memory (S[i], S[j], S[S[i]+S[j]]); the next request is taken
// in the XOR state, once the result register can load, so a new byte is
// taken while the last one finishes. The last key byte holds off requests
// through the key schedule: the read state ST_KS_RD, then for each step
// ST_KS_J (read S[j]), ST_KS_WJ (write S[j]) and ST_KS_WN (write S[n]).
// After reset the permutation is identity at once, held by per-entry valid
// flops, so there is no clearing pass.
module rc4_stream_cipher_unit
  import rc4_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire rc4_in_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output rc4_out_t      out_rsp_o
);

  localparam logic [8:0] KeyMax = 9'(MAX_KEY_BYTES);

  state_e     state_q, state_d;
  logic [7:0] i_q, i_d;
  logic [7:0] j_q, j_d;
  logic [7:0] si_q, si_d;
  logic [7:0] sj_q, sj_d;
  logic [7:0] t_q, t_d;
  logic [7:0] n_q, n_d;
  logic [7:0] kpos_q, kpos_d;
  logic [8:0] limit_q, limit_d;
  logic [8:0] key_count_q, key_count_d;
  logic [7:0] byte_q;
  logic       last_q;

  logic       out_valid_q, out_valid_d;
  rc4_out_t   out_q, out_d;

  // key store: read only at entries written for the current key, so no valid bits
  logic [7:0] key_mem [256];
  logic [7:0] key_rd_q;
  logic       key_wr;

  logic [7:0] rd_addr;
  logic [7:0] rd_data;
  perm_wr_t   wr;
  logic       perm_clr;

  logic       accept;
  logic       can_load;
  logic [8:0] count_next;
  logic [7:0] ks;
  logic [7:0] kb;
  logic [8:0] kpos_inc;

  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_XOR) && can_load);
  assign accept     = in_valid_i && in_ready_o;

  assign count_next = (key_count_q < KeyMax) ? key_count_q + 9'd1 : key_count_q;
  assign key_wr     = accept && (in_req_i.op == OP_KEY) && (key_count_q < KeyMax);

  // empty key: schedule adds zero
  assign kb       = (limit_q != 9'd0) ? key_rd_q : 8'd0;
  assign kpos_inc = {1'b0, kpos_q} + 9'd1;

  // keystream byte: S[t] after the swap; the writes of the swap may not
  // have landed yet, so take them from the swap registers
  always_comb begin
    if (t_q == i_q) begin
      ks = sj_q;
    end else if (t_q == j_q) begin
      ks = si_q;
    end else begin
      ks = rd_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    n_d         = n_q;
    kpos_d      = kpos_q;
    limit_d     = limit_q;
    key_count_d = key_count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_addr     = t_q;
    wr          = '0;
    perm_clr    = 1'b0;

    unique case (state_q)
      ST_IDLE, ST_XOR: begin
        if (state_q == ST_XOR) begin
          // second half of the swap: S[i] <= old S[j]
          wr.en   = 1'b1;
          wr.addr = i_q;
          wr.data = sj_q;
          if (can_load) begin
            out_valid_d       = 1'b1;
            out_d.out_byte    = byte_q ^ ks;
            out_d.out_last    = last_q;
            state_d           = ST_IDLE;
          end
        end
        if (accept) begin
          if (in_req_i.op == OP_DATA) begin
            i_d     = i_q + 8'd1;
            rd_addr = i_q + 8'd1;
            state_d = ST_RD_J;
          end else if (in_req_i.last) begin
            // new schedule: identity, indices zero
            perm_clr    = 1'b1;
            i_d         = '0;
            j_d         = '0;
            n_d         = '0;
            kpos_d      = '0;
            limit_d     = count_next;
            key_count_d = '0;
            state_d     = ST_KS_RD;
          end else begin
            key_count_d = count_next;
            state_d     = ST_IDLE;
          end
        end
      end

      ST_RD_J: begin
        si_d    = rd_data;
        j_d     = j_q + rd_data;
        rd_addr = j_q + rd_data;
        state_d = ST_RD_T;
      end

      ST_RD_T: begin
        sj_d    = rd_data;
        wr.en   = 1'b1;
        wr.addr = j_q;
        wr.data = si_q;
        t_d     = si_q + rd_data;
        rd_addr = si_q + rd_data;
        state_d = ST_XOR;
      end

      ST_KS_RD: begin
        rd_addr = n_q;
        state_d = ST_KS_J;
      end

      ST_KS_J: begin
        si_d    = rd_data;
        j_d     = j_q + rd_data + kb;
        rd_addr = j_q + rd_data + kb;
        if (limit_q != 9'd0) begin
          kpos_d = (kpos_inc >= limit_q) ? 8'd0 : kpos_inc[7:0];
        end
        state_d = ST_KS_WJ;
      end

      ST_KS_WJ: begin
        sj_d    = rd_data;
        wr.en   = 1'b1;
        wr.addr = j_q;
        wr.data = si_q;
        state_d = ST_KS_WN;
      end

      ST_KS_WN: begin
        wr.en   = 1'b1;
        wr.addr = n_q;
        wr.data = sj_q;
        if (&n_q) begin
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          n_d     = n_q + 8'd1;
          rd_addr = n_q + 8'd1;
          state_d = ST_KS_J;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kpos_q      <= '0;
      limit_q     <= '0;
      key_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      kpos_q      <= kpos_d;
      limit_q     <= limit_d;
      key_count_q <= key_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q  <= si_d;
    sj_q  <= sj_d;
    t_q   <= t_d;
    out_q <= out_d;
    if (accept) begin
      byte_q <= in_req_i.byte_in;
      last_q <= in_req_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_wr) begin
      key_mem[key_count_q[7:0]] <= in_req_i.byte_in;
    end
    key_rd_q <= key_mem[kpos_d];
  end

  rc4_perm_mem u_perm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (perm_clr),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/rc4_chk.sv =====
`default_nettype none

module rc4_chk
  import rc4_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire rc4_in_t  in_req_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire rc4_out_t out_rsp_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // result leaves only through a handshake
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without handshake");

  // a data request keeps the engine busy through ST_RD_J and ST_RD_T
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.op == OP_DATA)
      |=> !in_ready_o ##1 !in_ready_o)
    else $error("engine took a request during a keystream step");

  // the last key byte starts the schedule
  a_sched_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.op == OP_KEY) && in_req_i.last
      |=> !in_ready_o ##1 !in_ready_o)
    else $error("engine took a request during the key schedule");

endmodule

bind rc4_stream_cipher_unit rc4_chk u_rc4_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
